// ===== rtl/csma_pkg.sv =====
// csma_pkg: shared widths, register indexes and the configuration struct
// for the compression sensor moving average block; no dependencies
package csma_pkg;

  localparam int RAW_W         = 10;
  localparam int GAIN_W        = 7;
  localparam int DEPTH_W       = 16;
  localparam int CFG_IDX_W     = 3;
  localparam int CFG_DATA_W    = 16;
  localparam int WINDOW_LEN_DF = 8;

  localparam logic [RAW_W-1:0] FULL_SCALE = 10'd1023;

  localparam logic [CFG_IDX_W-1:0] REG_PRESSED_THRESHOLD = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN              = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_RANGE_CAP         = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_DEAD_ZONE         = 3'd3;

  localparam logic [RAW_W-1:0]   PRESSED_THRESHOLD_RST = 10'd1023;
  localparam logic [GAIN_W-1:0]  GAIN_RST              = 7'd1;
  localparam logic [DEPTH_W-1:0] RANGE_CAP_RST         = 16'd1023;
  localparam logic [DEPTH_W-1:0] DEAD_ZONE_RST         = 16'd0;

  typedef struct packed {
    logic [RAW_W-1:0]   pressed_threshold;
    logic [GAIN_W-1:0]  gain;
    logic [DEPTH_W-1:0] range_cap;
    logic [DEPTH_W-1:0] dead_zone;
  } cfg_t;

endpackage

// ===== rtl/csma_cond.sv =====
// csma_cond: per-sample conditioning (threshold, inversion, gain, cap, dead zone)
// depends on csma_pkg
module csma_cond (
  input  csma_pkg::cfg_t                cfg,
  input  logic [csma_pkg::RAW_W-1:0]    raw,
  output logic [csma_pkg::DEPTH_W-1:0]  cond
);
  import csma_pkg::*;

  localparam int PROD_W = RAW_W + GAIN_W;

  logic [RAW_W-1:0]  inv;
  logic [PROD_W-1:0] prod;

  assign inv  = FULL_SCALE - raw;
  assign prod = PROD_W'(inv) * PROD_W'(cfg.gain);

  always_comb begin
    if (raw > cfg.pressed_threshold) begin
      cond = '0;
    end else if (prod > PROD_W'(cfg.range_cap)) begin
      cond = cfg.range_cap;
    end else if (prod <= PROD_W'(cfg.dead_zone)) begin
      cond = '0;
    end else begin
      cond = prod[DEPTH_W-1:0];
    end
  end

endmodule

// ===== rtl/csma_window.sv =====
// csma_window: shift line of conditioned samples with a running window sum
// depends on csma_pkg
module csma_window #(
  parameter int WINDOW_LEN = csma_pkg::WINDOW_LEN_DF,
  parameter int SUM_W      = csma_pkg::DEPTH_W + $clog2(WINDOW_LEN)
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         shift_en,
  input  logic [csma_pkg::DEPTH_W-1:0] din,
  output logic [SUM_W-1:0]             sum
);
  import csma_pkg::*;

  logic [DEPTH_W-1:0] taps_r [WINDOW_LEN];
  logic [SUM_W-1:0]   sum_r;
  logic [SUM_W-1:0]   sum_nxt;

  assign sum_nxt = sum_r + SUM_W'(din) - SUM_W'(taps_r[WINDOW_LEN-1]);
  assign sum     = sum_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_r <= '0;
      for (int i = 0; i < WINDOW_LEN; i++) begin
        taps_r[i] <= '0;
      end
    end else if (shift_en) begin
      sum_r     <= sum_nxt;
      taps_r[0] <= din;
      for (int i = 1; i < WINDOW_LEN; i++) begin
        taps_r[i] <= taps_r[i-1];
      end
    end
  end

endmodule

// ===== rtl/compression_sensor_moving_average.sv =====
// compression_sensor_moving_average: top level, config registers, five-stage pipeline
// depends on csma_pkg, csma_cond, csma_window
//
//  channel | dir | handshake          | payload
//  in_     | in  | in_valid/in_stall   | in_raw_sample[9:0]
//  out_    | out | out_valid/out_stall | out_average_depth[15:0]
//  cfg_    | in  | cfg_valid/cfg_ready | cfg_index[2:0], cfg_data[15:0]
//
// one transaction per cycle while out_stall is low; out_valid is v4_r, the output stage
// stages: input reg, conditioned sample, window sum, reciprocal product, output reg
// the window mean uses a constant reciprocal multiply, set by WINDOW_LEN
// synchronous reset clears the window, sum and valid bits and loads config reset values
// a stalled output holds; bubbles collapse, so in_stall rises only when all stages are full
module compression_sensor_moving_average #(
  parameter int WINDOW_LEN = csma_pkg::WINDOW_LEN_DF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [csma_pkg::RAW_W-1:0]      in_raw_sample,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [csma_pkg::DEPTH_W-1:0]    out_average_depth,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [csma_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [csma_pkg::CFG_DATA_W-1:0] cfg_data
);
  import csma_pkg::*;

  localparam int LEN_W = $clog2(WINDOW_LEN);
  localparam int SUM_W = DEPTH_W + LEN_W;
  localparam int SHF   = SUM_W + LEN_W;
  localparam int M_W   = SHF + 1;
  localparam int P_W   = SUM_W + M_W;
  localparam logic [M_W-1:0] RECIP =
    M_W'(((64'd1 << SHF) + 64'(WINDOW_LEN) - 64'd1) / 64'(WINDOW_LEN));
  localparam logic [SUM_W-1:0] MAX_SUM = SUM_W'(WINDOW_LEN * 65535);

  cfg_t cfg_r;

  logic               v0_r, v1_r, v2_r, v3_r, v4_r;
  logic               rdy0, rdy1, rdy2, rdy3, rdy4;
  logic [RAW_W-1:0]   raw_r;
  logic [DEPTH_W-1:0] cond;
  logic [DEPTH_W-1:0] cond_r;
  logic [SUM_W-1:0]   sum;
  logic [P_W-1:0]     prod_r;
  logic [DEPTH_W-1:0] mean;
  logic [DEPTH_W-1:0] avg_r;

  // configuration
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.pressed_threshold <= PRESSED_THRESHOLD_RST;
      cfg_r.gain              <= GAIN_RST;
      cfg_r.range_cap         <= RANGE_CAP_RST;
      cfg_r.dead_zone         <= DEAD_ZONE_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_PRESSED_THRESHOLD: cfg_r.pressed_threshold <= cfg_data[RAW_W-1:0];
        REG_GAIN:              cfg_r.gain              <= cfg_data[GAIN_W-1:0];
        REG_RANGE_CAP:         cfg_r.range_cap         <= cfg_data[DEPTH_W-1:0];
        REG_DEAD_ZONE:         cfg_r.dead_zone         <= cfg_data[DEPTH_W-1:0];
        default: ;
      endcase
    end
  end

  // stage flow control
  assign rdy4     = !v4_r || !out_stall;
  assign rdy3     = !v3_r || rdy4;
  assign rdy2     = !v2_r || rdy3;
  assign rdy1     = !v1_r || rdy2;
  assign rdy0     = !v0_r || rdy1;
  assign in_stall = !rdy0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else begin
      if (rdy0) begin
        v0_r <= in_valid;
      end
      if (rdy1) begin
        v1_r <= v0_r;
      end
      if (rdy2) begin
        v2_r <= v1_r;
      end
      if (rdy3) begin
        v3_r <= v2_r;
      end
      if (rdy4) begin
        v4_r <= v3_r;
      end
    end
  end

  csma_cond u_cond (
    .cfg  (cfg_r),
    .raw  (raw_r),
    .cond (cond)
  );

  csma_window #(
    .WINDOW_LEN (WINDOW_LEN),
    .SUM_W      (SUM_W)
  ) u_window (
    .clk      (clk),
    .rst_n    (rst_n),
    .shift_en (v1_r && rdy2),
    .din      (cond_r),
    .sum      (sum)
  );

  assign mean = prod_r[SHF +: DEPTH_W];

  always_ff @(posedge clk) begin
    if (rdy0 && in_valid) begin
      raw_r <= in_raw_sample;
    end
    if (rdy1 && v0_r) begin
      cond_r <= cond;
    end
    if (rdy3 && v2_r) begin
      prod_r <= P_W'(sum) * P_W'(RECIP);
    end
    if (rdy4 && v3_r) begin
      avg_r <= (mean <= cfg_r.dead_zone) ? '0 : mean;
    end
  end

  assign out_valid         = v4_r;
  assign out_average_depth = avg_r;

  // checks
  a_sum_bound: assert property (@(posedge clk) disable iff (!rst_n)
    sum <= MAX_SUM)
    else $error("window sum above its bound");

  a_accept_loads: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> v0_r)
    else $error("accepted transaction not held in input stage");

  a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (v0_r && v1_r && v2_r && v3_r && v4_r && out_stall))
    else $error("input stalled with room in the pipeline");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("output valid right after reset");

endmodule
